// ===== design/sbg_pkg.sv =====
// ----------------------------------------------------------------------------
// sbg_pkg: shared types and constants
// Result word layout, group-to-character mapping and pending-bit codes
// for the six-bit group text encoder.
// ----------------------------------------------------------------------------
package sbg_pkg;

   localparam int unsigned DATA_W  = 8;
   localparam int unsigned GROUP_W = 6;
   localparam int unsigned PEND_W  = 4;   // at most 4 bits ever wait
   localparam int unsigned CNT_W   = 3;   // holds 0, 2 or 4

   localparam logic [CNT_W-1:0] CNT_ZERO = 3'd0;
   localparam logic [CNT_W-1:0] CNT_TWO  = 3'd2;
   localparam logic [CNT_W-1:0] CNT_FOUR = 3'd4;

   localparam logic [GROUP_W-1:0] UPPER_END = 6'd26;
   localparam logic [GROUP_W-1:0] LOWER_END = 6'd52;
   localparam logic [GROUP_W-1:0] DIGIT_END = 6'd62;

   localparam logic [DATA_W-1:0] UPPER_OFS = 8'd65;
   localparam logic [DATA_W-1:0] LOWER_OFS = 8'd71;
   localparam logic [DATA_W-1:0] DIGIT_OFS = 8'd4;

   typedef struct packed {
      logic [DATA_W-1:0] symbol;
      logic              symbol_valid;
      logic              end_of_text;
   } sbg_result_type;

   // Results produced by one byte; with two_res clear only first is used.
   typedef struct packed {
      sbg_result_type first;
      sbg_result_type second;
      logic           two_res;
   } sbg_pair_type;

   function automatic sbg_result_type make_result(input logic [GROUP_W-1:0] grp,
                                                  input logic               eot);
      sbg_result_type       res;
      logic [DATA_W-1:0]    g_ext;
      g_ext = {{(DATA_W-GROUP_W){1'b0}}, grp};
      res.end_of_text  = eot;
      res.symbol_valid = (grp < DIGIT_END);
      if (grp < UPPER_END) begin
         res.symbol = g_ext + UPPER_OFS;
      end else if (grp < LOWER_END) begin
         res.symbol = g_ext + LOWER_OFS;
      end else if (grp < DIGIT_END) begin
         res.symbol = g_ext - DIGIT_OFS;
      end else begin
         res.symbol = '0;
      end
      return res;
   endfunction

endpackage

// ===== design/sbg_req_if.sv =====
// ----------------------------------------------------------------------------
// sbg_req_if: input word channel
// Valid/ready channel carrying one text byte and its final flag.
// ----------------------------------------------------------------------------
interface sbg_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// ===== design/sbg_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sbg_rsp_if: result word channel
// Valid/ready channel carrying one encoded character per word.
// ----------------------------------------------------------------------------
interface sbg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       symbol_valid;
   logic       end_of_text;

   modport source (output valid, output symbol, output symbol_valid,
                   output end_of_text, input ready);
   modport sink   (input valid, input symbol, input symbol_valid,
                   input end_of_text, output ready);
endinterface

// ===== design/sbg_group_calc.sv =====
// ----------------------------------------------------------------------------
// sbg_group_calc: group split and character mapping
// Joins waiting bits with a new byte, cuts 6-bit groups, maps them to
// characters and computes the bits left waiting.
// ----------------------------------------------------------------------------
module sbg_group_calc
   import sbg_pkg::*;
(
   input  logic [PEND_W-1:0] pend_bits,
   input  logic [CNT_W-1:0]  pend_cnt,
   input  logic [DATA_W-1:0] data_byte,
   input  logic              final_byte,
   output sbg_pair_type      pair,
   output logic [PEND_W-1:0] next_bits,
   output logic [CNT_W-1:0]  next_cnt
);

   always_comb begin
      pair      = '0;
      next_bits = '0;
      next_cnt  = CNT_ZERO;
      case (pend_cnt)
         CNT_TWO: begin
            // 10 bits: one group, 4 left
            pair.first = make_result({pend_bits[1:0], data_byte[7:4]}, 1'b0);
            if (final_byte) begin
               pair.second  = make_result({2'b00, data_byte[3:0]}, 1'b1);
               pair.two_res = 1'b1;
            end else begin
               next_bits = data_byte[3:0];
               next_cnt  = CNT_FOUR;
            end
         end
         CNT_FOUR: begin
            // 12 bits: two groups, nothing left
            pair.first   = make_result({pend_bits, data_byte[7:6]}, 1'b0);
            pair.second  = make_result(data_byte[5:0], final_byte);
            pair.two_res = 1'b1;
         end
         default: begin
            // 8 bits: one group, 2 left
            pair.first = make_result(data_byte[7:2], 1'b0);
            if (final_byte) begin
               pair.second  = make_result({4'b0000, data_byte[1:0]}, 1'b1);
               pair.two_res = 1'b1;
            end else begin
               next_bits = {2'b00, data_byte[1:0]};
               next_cnt  = CNT_TWO;
            end
         end
      endcase
   end

endmodule

// ===== design/sbg_result_buf.sv =====
// ----------------------------------------------------------------------------
// sbg_result_buf: result register pair
// Holds a byte's one or two results and hands them out in order, one word
// per cycle while ready is high. Reloads in the cycle the last word leaves.
// ----------------------------------------------------------------------------
module sbg_result_buf
   import sbg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  sbg_pair_type   pair,
   output logic           can_load,
   sbg_rsp_if.source      rsp_if
);

   // words left: 2 shows slot0, 1 shows slot1
   logic [1:0]     left_ff, left_in;
   sbg_result_type slot0_ff, slot0_in;
   sbg_result_type slot1_ff, slot1_in;
   sbg_result_type cur;
   logic           pop;

   assign pop      = rsp_if.valid & rsp_if.ready;
   assign can_load = (left_ff == 2'd0) || ((left_ff == 2'd1) && rsp_if.ready);

   always_comb begin
      left_in  = left_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         left_in = left_ff - 2'd1;
      end
      if (load) begin
         if (pair.two_res) begin
            left_in  = 2'd2;
            slot0_in = pair.first;
            slot1_in = pair.second;
         end else begin
            left_in  = 2'd1;
            slot1_in = pair.first;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 2'd0;
      end else begin
         left_ff <= left_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign cur = (left_ff == 2'd2) ? slot0_ff : slot1_ff;

   assign rsp_if.valid        = (left_ff != 2'd0);
   assign rsp_if.symbol       = cur.symbol;
   assign rsp_if.symbol_valid = cur.symbol_valid;
   assign rsp_if.end_of_text  = cur.end_of_text;

endmodule

// ===== design/six_bit_group_text_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// six_bit_group_text_encoder_unit: byte stream to 6-bit group characters
// Top level: input register, group logic, waiting-bit state, result pair.
// ----------------------------------------------------------------------------
// Each accepted word is one text byte; its bits join any waiting bits and
// every full 6-bit group leaves as one result word, mapped to A-Z, a-z,
// 0-9. Groups 62 and 63 leave as a word with symbol_valid low and symbol
// zero. A byte flagged final flushes 2 or 4 leftover bits right-aligned
// as one extra word and sets end_of_text on its last word; the waiting
// bits then start over empty. A byte yields one or two words, and the
// single result port sends one word per cycle while rsp_if.ready is
// high. Inside a text the waiting bits go 0, 2, 4 and back to 0, so
// three bytes give four words; a final byte, or one met with 4 bits
// waiting, yields two words. A byte accepted into the input register
// moves into the result pair when the pair is free, and its first word
// then shows on rsp_if. A new byte is accepted while the last word of
// the previous one is still waiting to be taken.
// ----------------------------------------------------------------------------
module six_bit_group_text_encoder_unit
   import sbg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   sbg_req_if.sink    req_if,
   sbg_rsp_if.source  rsp_if
);

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [DATA_W-1:0] in_byte_ff, in_byte_in;
   logic              in_final_ff, in_final_in;

   // waiting bits, right-aligned, and how many count (0, 2, 4)
   logic [PEND_W-1:0] pend_bits_ff, pend_bits_in;
   logic [CNT_W-1:0]  pend_cnt_ff, pend_cnt_in;

   sbg_pair_type      pair;
   logic [PEND_W-1:0] next_bits;
   logic [CNT_W-1:0]  next_cnt;
   logic              can_load;
   logic              move;
   logic              take;

   // byte in the input register moves on when the result pair frees up
   assign move          = in_valid_ff & can_load;
   assign req_if.ready  = ~in_valid_ff | can_load;
   assign take          = req_if.valid & req_if.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_final_in  = in_final_ff;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      if (move) begin
         in_valid_in  = 1'b0;
         pend_bits_in = next_bits;
         pend_cnt_in  = next_cnt;
      end
      if (take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_if.data_byte;
         in_final_in = req_if.final_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= CNT_ZERO;
      end else begin
         in_valid_ff  <= in_valid_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
      in_byte_ff  <= in_byte_in;
      in_final_ff <= in_final_in;
   end

   sbg_group_calc u_calc (
      .pend_bits  (pend_bits_ff),
      .pend_cnt   (pend_cnt_ff),
      .data_byte  (in_byte_ff),
      .final_byte (in_final_ff),
      .pair       (pair),
      .next_bits  (next_bits),
      .next_cnt   (next_cnt)
   );

   sbg_result_buf u_rbuf (
      .clock    (clock),
      .reset    (reset),
      .load     (move),
      .pair     (pair),
      .can_load (can_load),
      .rsp_if   (rsp_if)
   );

endmodule
